[hw/rtl/edi_pkg.sv]
// Shared types and constants for the Euclidean distance / integer square root core.
// No dependencies; imported by the core and by its checker.
`default_nettype none

package edi_pkg;

    // Result field widths, fixed whatever the coordinate width
    localparam int SQ_W   = 31;                   // distance_squared
    localparam int ROOT_W = 16;                   // distance
    localparam int OUT_W  = ((SQ_W + ROOT_W + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - SQ_W - ROOT_W;

    // Root extractor: one radicand digit pair per step
    localparam int ROOT_STEPS = ROOT_W;
    localparam int RT_CNT_W   = $clog2(ROOT_STEPS);
    localparam int OP_W       = 2 * ROOT_W;       // radicand, padded to whole pairs
    localparam int REM_W      = ROOT_W + 1;       // partial remainder never exceeds 2*root
    localparam int TRY_W      = REM_W + 2;        // remainder with next pair appended

    typedef enum logic [2:0]
    {
        SQ_IDLE = 3'b001,
        SQ_RUN  = 3'b010,
        SQ_DONE = 3'b100
    } sq_state_t;

    typedef enum logic [2:0]
    {
        RT_IDLE = 3'b001,
        RT_RUN  = 3'b010,
        RT_DONE = 3'b100
    } rt_state_t;

endpackage

`default_nettype wire

[hw/rtl/euclidean_distance_isqrt_core.sv]
// Planar Euclidean distance core: bit-serial squarer feeding a digit-serial square root.
// Depends on edi_pkg.
`default_nettype none

// ---------------------------------------------------------------------------
// Usage
//   Slave stream (s_*): one beat carries both points. A beat is taken when
//   s_tvalid and s_tready are high at a rising edge of clk.
//   Master stream (m_*): one beat per input beat, carrying the squared
//   distance and its floor square root, same order as the inputs.
//
// Timing
//   The squarer retires one multiplier bit per cycle; the root extractor
//   resolves one result bit from two radicand bits per cycle. The two
//   units overlap on successive beats: the squarer can take a new beat
//   while the root extractor still works on the previous one.
//
// Reset and back-pressure
//   rst_n clears both units and the output register; a beat in flight is
//   dropped and none is invented. If m_tready is low, the finished result waits
//   in the output register; the root extractor holds its next result, the
//   squarer holds behind it, and s_tready drops once the squarer is full.
// ---------------------------------------------------------------------------
module euclidean_distance_isqrt_core
    import edi_pkg::*;
#(
    parameter int COORD_BITS = 15
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // first_x, first_y, second_x, second_y (COORD_BITS each), zero pad to bytes
    input  wire logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // distance_squared [30:0], distance [46:31], zero pad [47]
    output logic [OUT_W-1:0]           m_tdata
);

    localparam int CB     = COORD_BITS;
    localparam int SQ_CNT_W = $clog2(CB);

    // ---------------------------------------------------------------
    // Input unpack and absolute differences
    // ---------------------------------------------------------------
    logic [CB-1:0] ax, ay, bx, by;
    logic [CB-1:0] dx, dy;

    assign ax = s_tdata[CB-1:0];
    assign ay = s_tdata[2*CB-1:CB];
    assign bx = s_tdata[3*CB-1:2*CB];
    assign by = s_tdata[4*CB-1:3*CB];

    assign dx = (ax >= bx) ? (ax - bx) : (bx - ax);
    assign dy = (ay >= by) ? (ay - by) : (by - ay);

    // ---------------------------------------------------------------
    // Squarer: serial-parallel multiply of dx*dx and dy*dy in one pass.
    // Multiplier bits leave LSB first; the partial sum drops its low bit
    // into prod_lo each cycle, so the adder is only CB+2 bits wide.
    // ---------------------------------------------------------------
    sq_state_t     sq_state_reg, sq_state_next;
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;

    logic [CB-1:0] mcand_x_reg, mcand_y_reg;
    logic [CB-1:0] mplier_x_reg, mplier_x_next;
    logic [CB-1:0] mplier_y_reg, mplier_y_next;
    logic [CB:0]   acc_hi_reg, acc_hi_next;
    logic [CB-1:0] prod_lo_reg, prod_lo_next;

    logic [CB-1:0] pp_x, pp_y;
    logic [CB+1:0] pp_sum;
    logic          s_fire;
    logic          handoff;

    assign s_tready = (sq_state_reg == SQ_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign pp_x   = mplier_x_reg[0] ? mcand_x_reg : '0;
    assign pp_y   = mplier_y_reg[0] ? mcand_y_reg : '0;
    assign pp_sum = {1'b0, acc_hi_reg} + {2'b00, pp_x} + {2'b00, pp_y};

    // ---------------------------------------------------------------
    // Root extractor: restoring digit-by-digit square root, two radicand
    // bits shifted in per cycle from the top of op_reg.
    // ---------------------------------------------------------------
    rt_state_t     rt_state_reg, rt_state_next;
    logic [RT_CNT_W-1:0] rt_cnt_reg, rt_cnt_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0]   rt_dsq_reg, rt_dsq_next;

    logic [SQ_W-1:0]   sq_result;
    logic [TRY_W-1:0]  rem_shift;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  rem_diff;
    logic              take_bit;

    assign sq_result = SQ_W'({acc_hi_reg, prod_lo_reg});
    assign handoff   = (sq_state_reg == SQ_DONE) && (rt_state_reg == RT_IDLE);

    assign rem_shift = {rem_reg, op_reg[OP_W-1 -: 2]};
    assign trial     = TRY_W'({root_reg, 2'b01});
    assign take_bit  = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic              out_valid_reg, out_valid_next;
    logic [SQ_W-1:0]   out_dsq_reg, out_dsq_next;
    logic [ROOT_W-1:0] out_root_reg, out_root_next;
    logic              out_load;

    assign out_load = (rt_state_reg == RT_DONE) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_root_reg, out_dsq_reg};

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb
    begin
        sq_state_next = sq_state_reg;
        sq_cnt_next   = sq_cnt_reg;
        mplier_x_next = mplier_x_reg;
        mplier_y_next = mplier_y_reg;
        acc_hi_next   = acc_hi_reg;
        prod_lo_next  = prod_lo_reg;

        unique case (sq_state_reg)
            SQ_IDLE:
            begin
                if (s_fire)
                begin
                    sq_state_next = SQ_RUN;
                    sq_cnt_next   = '0;
                    mplier_x_next = dx;
                    mplier_y_next = dy;
                    acc_hi_next   = '0;
                    prod_lo_next  = '0;
                end
            end
            SQ_RUN:
            begin
                acc_hi_next   = pp_sum[CB+1:1];
                prod_lo_next  = {pp_sum[0], prod_lo_reg[CB-1:1]};
                mplier_x_next = mplier_x_reg >> 1;
                mplier_y_next = mplier_y_reg >> 1;
                sq_cnt_next   = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == SQ_CNT_W'(CB - 1))
                begin
                    sq_state_next = SQ_DONE;
                end
            end
            SQ_DONE:
            begin
                if (handoff)
                begin
                    sq_state_next = SQ_IDLE;
                end
            end
            default:
            begin
                sq_state_next = SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rt_state_next = rt_state_reg;
        rt_cnt_next   = rt_cnt_reg;
        op_next       = op_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        rt_dsq_next   = rt_dsq_reg;

        unique case (rt_state_reg)
            RT_IDLE:
            begin
                if (handoff)
                begin
                    rt_state_next = RT_RUN;
                    rt_cnt_next   = '0;
                    op_next       = OP_W'(sq_result);
                    rem_next      = '0;
                    root_next     = '0;
                    rt_dsq_next   = sq_result;
                end
            end
            RT_RUN:
            begin
                op_next     = op_reg << 2;
                rt_cnt_next = rt_cnt_reg + 1'b1;
                if (take_bit)
                begin
                    rem_next  = rem_diff[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (rt_cnt_reg == RT_CNT_W'(ROOT_STEPS - 1))
                begin
                    rt_state_next = RT_DONE;
                end
            end
            RT_DONE:
            begin
                if (out_load)
                begin
                    rt_state_next = RT_IDLE;
                end
            end
            default:
            begin
                rt_state_next = RT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_dsq_next   = out_dsq_reg;
        out_root_next  = out_root_reg;

        priority if (out_load)
        begin
            out_valid_next = 1'b1;
            out_dsq_next   = rt_dsq_reg;
            out_root_next  = root_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Registers: control with reset, payload without
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_state_reg  <= SQ_IDLE;
            sq_cnt_reg    <= '0;
            rt_state_reg  <= RT_IDLE;
            rt_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sq_state_reg  <= sq_state_next;
            sq_cnt_reg    <= sq_cnt_next;
            rt_state_reg  <= rt_state_next;
            rt_cnt_reg    <= rt_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            mcand_x_reg <= dx;
            mcand_y_reg <= dy;
        end
        mplier_x_reg <= mplier_x_next;
        mplier_y_reg <= mplier_y_next;
        acc_hi_reg   <= acc_hi_next;
        prod_lo_reg  <= prod_lo_next;
        op_reg       <= op_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        rt_dsq_reg   <= rt_dsq_next;
        out_dsq_reg  <= out_dsq_next;
        out_root_reg <= out_root_next;
    end

endmodule

`default_nettype wire

[hw/rtl/edi_checker.sv]
// Port-level checks for euclidean_distance_isqrt_core, attached by bind.
// Depends on edi_pkg and on the core's port list.
`default_nettype none

module edi_checker
    import edi_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_W-1:0]      m_tdata
);

    logic [ROOT_W:0]     root_p1;
    logic [2*ROOT_W+1:0] root_sq;
    logic [2*ROOT_W+1:0] root_p1_sq;
    logic [2*ROOT_W+1:0] dsq;

    assign root_p1    = {1'b0, m_tdata[SQ_W +: ROOT_W]} + 1'b1;
    assign root_sq    = (2*ROOT_W+2)'(m_tdata[SQ_W +: ROOT_W]) *
                        (2*ROOT_W+2)'(m_tdata[SQ_W +: ROOT_W]);
    assign root_p1_sq = (2*ROOT_W+2)'(root_p1) * (2*ROOT_W+2)'(root_p1);
    assign dsq        = (2*ROOT_W+2)'(m_tdata[SQ_W-1:0]);

    // held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // the two result fields agree: distance is the floor root of distance_squared
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (root_sq <= dsq) && (root_p1_sq > dsq))
        else $error("distance is not the floor root of distance_squared");

    // taking a beat fills the squarer and drops s_tready
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a beat");

    // nothing offered while held in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid && s_tready)
        else $error("outputs active during reset");

endmodule

bind euclidean_distance_isqrt_core edi_checker u_edi_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
